>>> hdl/pbd_pkg.sv
`timescale 1ns / 1ps

package pbd_pkg;

	// field widths
	localparam int unsigned SAMPLE_W   = 10;
	localparam int unsigned TIME_W     = 32;
	localparam int unsigned THRESH_W   = 4;
	localparam int unsigned INTERVAL_W = 16;
	localparam int unsigned BEATS_W    = 16;
	localparam int unsigned WSUM_W     = 12;

	// stream packing, padded to whole bytes
	localparam int unsigned S_TDATA_W = 48;
	localparam int unsigned M_TDATA_W = 32;

	// configuration port
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RISE_THRESHOLD   = 1'b0,
		REG_MIN_BEAT_INTERVAL = 1'b1
	} cfg_reg_t;

	localparam logic [THRESH_W-1:0]   RISE_THRESHOLD_RST = 4'd4;
	localparam logic [INTERVAL_W-1:0] MIN_INTERVAL_RST   = 16'd300;

	localparam logic [THRESH_W-1:0] RISE_MAX  = '1;
	localparam logic [BEATS_W-1:0]  BEATS_MAX = '1;

	// status of the moving average for the sample being applied
	typedef struct packed {
		logic              rise;
		logic [WSUM_W-1:0] window_sum;
	} avg_stat_t;

endpackage

>>> hdl/pbd_avg.sv
`timescale 1ns / 1ps

module pbd_avg #(
	parameter int unsigned WINDOW = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic [pbd_pkg::SAMPLE_W-1:0]   sample,
	output pbd_pkg::avg_stat_t             stat
);

	localparam int unsigned PTR_W = $clog2(WINDOW);
	localparam int unsigned SUM_W = pbd_pkg::SAMPLE_W + $clog2(WINDOW);
	localparam int unsigned EXT_W = (SUM_W > pbd_pkg::WSUM_W) ? SUM_W : pbd_pkg::WSUM_W;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW - 1);

	logic [pbd_pkg::SAMPLE_W-1:0] ring_q [WINDOW];
	logic [PTR_W-1:0]             ptr_q;
	logic [SUM_W-1:0]             sum_q;
	logic [SUM_W-1:0]             prev_sum_q;
	logic [SUM_W-1:0]             sum_next;
	logic [EXT_W-1:0]             sum_ext;

	// oldest sample leaves, new one enters
	assign sum_next = sum_q - SUM_W'(ring_q[ptr_q]) + SUM_W'(sample);
	assign sum_ext  = EXT_W'(sum_next);

	assign stat.rise       = (sum_next > prev_sum_q);
	assign stat.window_sum = sum_ext[pbd_pkg::WSUM_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW; i++) begin
				ring_q[i] <= '0;
			end
			ptr_q      <= '0;
			sum_q      <= '0;
			prev_sum_q <= '0;
		end else if (en) begin
			ring_q[ptr_q] <= sample;
			ptr_q         <= (ptr_q == PTR_LAST) ? '0 : ptr_q + 1'b1;
			sum_q         <= sum_next;
			prev_sum_q    <= sum_next;
		end
	end

endmodule

>>> hdl/pulse_beat_detector.sv
`timescale 1ns / 1ps

// channel   dir  width  contents (lowest bit first)
// s_*       in   48     sample[9:0], now_ms[41:10], zero pad
// m_*       out  32     beat[0], beats_total[16:1], window_sum[28:17], zero pad
// wr_*      in   1+16   register index, write data; no read-back
//
// a sample beat passes from input to result through the input register, then
// through the update logic into the result register
// sustained rate is one beat per cycle; the input register and result register
// stall together when m_tready is low and a result is already waiting
// arst_n clears all detector state, the sample ring and the registers to
// their defaults (rise_threshold 4, min_beat_interval_ms 300)

module pulse_beat_detector #(
	parameter int unsigned WINDOW = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// sample stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [pbd_pkg::S_TDATA_W-1:0]     s_tdata,   // sample, now_ms
	// result stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [pbd_pkg::M_TDATA_W-1:0]     m_tdata,   // beat, beats_total, window_sum
	// register writes
	input  logic                              wr_en,
	input  logic [pbd_pkg::CFG_IDX_W-1:0]     wr_index,
	input  logic [pbd_pkg::CFG_DATA_W-1:0]    wr_data
);

	// configuration
	logic [pbd_pkg::THRESH_W-1:0]   rise_threshold_q;
	logic [pbd_pkg::INTERVAL_W-1:0] min_interval_q;

	// input register
	logic                           valid_s1;
	logic [pbd_pkg::SAMPLE_W-1:0]   sample_s1;
	logic [pbd_pkg::TIME_W-1:0]     now_s1;

	// detector state
	logic                           rising_q;
	logic [pbd_pkg::THRESH_W-1:0]   rise_cnt_q;
	logic [pbd_pkg::TIME_W-1:0]     last_beat_q;
	logic [pbd_pkg::BEATS_W-1:0]    beats_q;

	// result register
	logic                           out_valid_q;
	logic                           beat_q;
	logic [pbd_pkg::BEATS_W-1:0]    beats_out_q;
	logic [pbd_pkg::WSUM_W-1:0]     wsum_q;

	// update logic
	logic                           out_free;
	logic                           adv;
	pbd_pkg::avg_stat_t             avg;
	logic [pbd_pkg::THRESH_W-1:0]   rise_cnt_next;
	logic [pbd_pkg::TIME_W-1:0]     elapsed;
	logic                           peak_start;
	logic                           beat_now;
	logic                           rising_next;
	logic [pbd_pkg::BEATS_W-1:0]    beats_next;

	// result register can take a new value when empty or being drained
	assign out_free = !out_valid_q || m_tready;
	assign adv      = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	// config writes must arrive only while idle; the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rise_threshold_q <= pbd_pkg::RISE_THRESHOLD_RST;
			min_interval_q   <= pbd_pkg::MIN_INTERVAL_RST;
		end else if (wr_en) begin
			case (wr_index)
				pbd_pkg::REG_RISE_THRESHOLD: begin
					rise_threshold_q <= wr_data[pbd_pkg::THRESH_W-1:0];
				end
				pbd_pkg::REG_MIN_BEAT_INTERVAL: begin
					min_interval_q <= wr_data[pbd_pkg::INTERVAL_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			sample_s1 <= s_tdata[pbd_pkg::SAMPLE_W-1:0];
			now_s1    <= s_tdata[pbd_pkg::SAMPLE_W +: pbd_pkg::TIME_W];
		end
	end

	// moving sum and rise compare
	pbd_avg #(
		.WINDOW (WINDOW)
	) u_avg (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.sample (sample_s1),
		.stat   (avg)
	);

	// rise counting and debounce
	always_comb begin
		elapsed = now_s1 - last_beat_q;
		if (avg.rise) begin
			rise_cnt_next = (rise_cnt_q == pbd_pkg::RISE_MAX) ? rise_cnt_q : rise_cnt_q + 1'b1;
		end else begin
			rise_cnt_next = '0;
		end
		// first sample of this rise above the threshold
		peak_start  = avg.rise && (rise_cnt_next > rise_threshold_q) && !rising_q;
		beat_now    = peak_start && (elapsed > pbd_pkg::TIME_W'(min_interval_q));
		if (avg.rise) begin
			rising_next = rising_q || peak_start;
		end else begin
			rising_next = 1'b0;
		end
		if (beat_now && (beats_q != pbd_pkg::BEATS_MAX)) begin
			beats_next = beats_q + 1'b1;
		end else begin
			beats_next = beats_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rising_q    <= 1'b0;
			rise_cnt_q  <= '0;
			last_beat_q <= '0;
			beats_q     <= '0;
		end else if (adv) begin
			rising_q   <= rising_next;
			rise_cnt_q <= rise_cnt_next;
			beats_q    <= beats_next;
			if (beat_now) begin
				last_beat_q <= now_s1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			beat_q      <= beat_now;
			beats_out_q <= beats_next;
			wsum_q      <= avg.window_sum;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = pbd_pkg::M_TDATA_W'({wsum_q, beats_out_q, beat_q});

endmodule

>>> test/tb_pulse_beat_detector.sv
`timescale 1ns / 1ps

module tb_pulse_beat_detector;

	localparam int unsigned WIN          = 4;
	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned DRAIN_CYCLES = 6;
	localparam int unsigned REPORT_MAX   = 10;

	// one result beat as the detector reports it
	typedef struct packed {
		logic                        beat;
		logic [pbd_pkg::BEATS_W-1:0] total;
		logic [pbd_pkg::WSUM_W-1:0]  wsum;
	} beat_report_t;

	// one row of the opening sequence; typed rows carry their own answer
	typedef struct packed {
		logic [pbd_pkg::SAMPLE_W-1:0] sample;
		logic [pbd_pkg::TIME_W-1:0]   stamp;
		logic                         typed;
		beat_report_t                 want;
	} pulse_row_t;

	logic                           clk      = 1'b0;
	logic                           arst_n   = 1'b0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [pbd_pkg::S_TDATA_W-1:0]  s_tdata  = '0;   // sample, now_ms
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [pbd_pkg::M_TDATA_W-1:0]  m_tdata;         // beat, beats_total, window_sum
	logic                           wr_en    = 1'b0;
	logic [pbd_pkg::CFG_IDX_W-1:0]  wr_index = '0;
	logic [pbd_pkg::CFG_DATA_W-1:0] wr_data  = '0;

	pulse_beat_detector #(.WINDOW(WIN)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// mirror of the detector state and its registers
	logic [pbd_pkg::SAMPLE_W-1:0]   ring_mirror [WIN];
	int unsigned                    ring_at;
	int unsigned                    run_sum;
	int unsigned                    prev_sum;
	logic                           rising;
	logic [pbd_pkg::THRESH_W-1:0]   rise_run;
	logic [pbd_pkg::TIME_W-1:0]     last_beat_ms;
	logic [pbd_pkg::BEATS_W-1:0]    beat_tally;
	logic [pbd_pkg::THRESH_W-1:0]   thr_cfg;
	logic [pbd_pkg::INTERVAL_W-1:0] gap_cfg;

	beat_report_t beat_reports_due [$];

	int unsigned cycles       = 0;
	int unsigned items_sent   = 0;
	int unsigned reports_seen = 0;
	int unsigned beats_seen   = 0;
	int unsigned fails        = 0;
	bit          steady       = 1'b0;
	logic [pbd_pkg::TIME_W-1:0] clock_ms = '0;

	// opening sequence at reset register values (threshold 4, debounce 300)
	pulse_row_t warmup_rows [25] = '{
		// flat zero step right after reset: no rise, nothing counted
		'{10'd0,    32'd0,   1'b1, '{1'b0, 16'd0, 12'd0}},
		// five rises inside the first 300 ms: early beat is held off
		'{10'd1,    32'd10,  1'b0, '0},
		'{10'd2,    32'd20,  1'b0, '0},
		'{10'd3,    32'd30,  1'b0, '0},
		'{10'd4,    32'd40,  1'b0, '0},
		'{10'd5,    32'd50,  1'b0, '0},
		// fall clears the rise count
		'{10'd0,    32'd60,  1'b0, '0},
		// proper rise well past the debounce: first counted beat
		'{10'd600,  32'd400, 1'b0, '0},
		'{10'd700,  32'd410, 1'b0, '0},
		'{10'd800,  32'd420, 1'b0, '0},
		'{10'd900,  32'd430, 1'b0, '0},
		'{10'd1000, 32'd440, 1'b0, '0},
		// full scale ring: largest window sum, still one beat
		'{10'd1023, 32'd450, 1'b0, '0},
		'{10'd1023, 32'd460, 1'b0, '0},
		'{10'd1023, 32'd470, 1'b0, '0},
		'{10'd1023, 32'd480, 1'b1, '{1'b0, 16'd1, 12'd4092}},
		// drain the ring back to zero
		'{10'd0,    32'd490, 1'b0, '0},
		'{10'd0,    32'd500, 1'b0, '0},
		'{10'd0,    32'd510, 1'b0, '0},
		'{10'd0,    32'd515, 1'b1, '{1'b0, 16'd1, 12'd0}},
		// second rise inside the debounce interval: no beat
		'{10'd100,  32'd520, 1'b0, '0},
		'{10'd200,  32'd530, 1'b0, '0},
		'{10'd300,  32'd540, 1'b0, '0},
		'{10'd400,  32'd550, 1'b0, '0},
		'{10'd500,  32'd560, 1'b0, '0}
	};

	function automatic bit idle_draw();
		return !steady && ($urandom_range(0, 99) < 12);
	endfunction

	// advance the mirror by one sample and return the report it calls for
	function automatic beat_report_t track_pulse(input logic [pbd_pkg::SAMPLE_W-1:0] smp,
			input logic [pbd_pkg::TIME_W-1:0] stamp);
		beat_report_t               r;
		logic [pbd_pkg::TIME_W-1:0] since;
		r.beat = 1'b0;
		run_sum = run_sum - ring_mirror[ring_at] + smp;
		ring_mirror[ring_at] = smp;
		ring_at = (ring_at == WIN - 1) ? 0 : ring_at + 1;
		if (run_sum > prev_sum) begin
			if (rise_run != pbd_pkg::RISE_MAX)
				rise_run++;
			if (rise_run > thr_cfg && !rising) begin
				// wrapping distance since the last counted beat
				since = stamp - last_beat_ms;
				if (since > pbd_pkg::TIME_W'(gap_cfg)) begin
					r.beat = 1'b1;
					if (beat_tally != pbd_pkg::BEATS_MAX)
						beat_tally++;
					last_beat_ms = stamp;
				end
				rising = 1'b1;
			end
		end else begin
			rising   = 1'b0;
			rise_run = '0;
		end
		prev_sum = run_sum;
		r.total  = beat_tally;
		r.wsum   = run_sum[pbd_pkg::WSUM_W-1:0];
		return r;
	endfunction

	// offer one sample beat; the mirror moves at the accepting edge
	task automatic push_sample(input logic [pbd_pkg::SAMPLE_W-1:0] smp,
			input logic [pbd_pkg::TIME_W-1:0] stamp,
			input logic typed, input beat_report_t want);
		beat_report_t pred;
		while (idle_draw()) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= pbd_pkg::S_TDATA_W'({stamp, smp});
		do @(posedge clk); while (!s_tready);
		pred = track_pulse(smp, stamp);
		beat_reports_due.push_back(typed ? want : pred);
		items_sent++;
	endtask

	// stop offering samples and wait until every report is back
	task automatic settle();
		s_tvalid <= 1'b0;
		while (beat_reports_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// both registers back to back; only called with the detector idle
	task automatic configure(input logic [pbd_pkg::THRESH_W-1:0] thr,
			input logic [pbd_pkg::INTERVAL_W-1:0] gap);
		wr_en    <= 1'b1;
		wr_index <= pbd_pkg::REG_RISE_THRESHOLD;
		wr_data  <= pbd_pkg::CFG_DATA_W'(thr);
		@(posedge clk);
		thr_cfg   = thr;
		wr_index <= pbd_pkg::REG_MIN_BEAT_INTERVAL;
		wr_data  <= gap;
		@(posedge clk);
		gap_cfg = gap;
		wr_en  <= 1'b0;
	endtask

	task automatic emit(input logic [pbd_pkg::SAMPLE_W-1:0] smp);
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 2)
			clock_ms = clock_ms;               // repeated timestamp
		else if (pick < 7)
			clock_ms += $urandom_range(0, 2000);
		else
			clock_ms += $urandom_range(5, 60);
		push_sample(smp, clock_ms, 1'b0, '0);
	endtask

	// mostly pulse shaped rise and fall runs, plus noise, plateaus and broken ramps
	task automatic pulse_traffic(input int unsigned n);
		int unsigned target, shape, len, lvl, stride, dip_at, i;
		target = items_sent + n;
		while (items_sent < target) begin
			// occasional clock jumps: anywhere, near the wrap, or far ahead
			case ($urandom_range(0, 31))
				0: clock_ms = $urandom();
				1: clock_ms = 32'hFFFF_FF00 + $urandom_range(0, 255);
				2: clock_ms += $urandom_range(60000, 200000);
				default: ;
			endcase
			shape = $urandom_range(0, 9);
			if (shape <= 6) begin
				lvl    = $urandom_range(0, 300);
				len    = $urandom_range(1, 18);
				stride = $urandom_range(1, 40);
				dip_at = ($urandom_range(0, 3) == 0) ? $urandom_range(1, len) : 0;
				for (i = 1; i <= len; i++) begin
					lvl = (lvl + stride > 1023) ? 1023 : lvl + stride;
					// broken ramp: one low sample in the middle of the rise
					emit(pbd_pkg::SAMPLE_W'((i == dip_at) ? lvl / 2 : lvl));
				end
				len = $urandom_range(1, 6);
				for (i = 0; i < len; i++) begin
					stride = $urandom_range(20, 200);
					lvl    = (lvl > stride) ? lvl - stride : 0;
					emit(pbd_pkg::SAMPLE_W'(lvl));
				end
			end else if (shape <= 8) begin
				len = $urandom_range(1, 8);
				for (i = 0; i < len; i++)
					emit(pbd_pkg::SAMPLE_W'($urandom_range(0, 1023)));
			end else begin
				lvl = $urandom_range(0, 1023);
				len = $urandom_range(2, 8);
				for (i = 0; i < len; i++)
					emit(pbd_pkg::SAMPLE_W'(lvl));
			end
		end
	endtask

	// result side: random back-pressure
	always @(posedge clk)
		m_tready <= !idle_draw();

	// result checking and the run limit
	always @(posedge clk) begin
		beat_report_t got, due;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d reports outstanding", cycles,
				beat_reports_due.size());
			$display("FAIL pulse_beat_detector");
			$finish;
		end else if (arst_n && m_tvalid && m_tready) begin
			got.beat  = m_tdata[0];
			got.total = m_tdata[pbd_pkg::BEATS_W:1];
			got.wsum  = m_tdata[pbd_pkg::BEATS_W+pbd_pkg::WSUM_W:pbd_pkg::BEATS_W+1];
			reports_seen++;
			if (got.beat)
				beats_seen++;
			if (beat_reports_due.size() == 0) begin
				fails++;
				if (fails <= REPORT_MAX)
					$display("unexpected report at cycle %0d: beat %0b total %0d sum %0d",
						cycles, got.beat, got.total, got.wsum);
			end else begin
				due = beat_reports_due.pop_front();
				if (got != due) begin
					fails++;
					if (fails <= REPORT_MAX)
						$display("report %0d mismatch: beat %0b/%0b total %0d/%0d sum %0d/%0d %s",
							reports_seen, due.beat, got.beat, due.total, got.total,
							due.wsum, got.wsum, "(expected/actual)");
				end
			end
		end
	end

	initial begin
		int unsigned k;
		for (k = 0; k < WIN; k++)
			ring_mirror[k] = '0;
		ring_at      = 0;
		run_sum      = 0;
		prev_sum     = 0;
		rising       = 1'b0;
		rise_run     = '0;
		last_beat_ms = '0;
		beat_tally   = '0;
		thr_cfg      = pbd_pkg::RISE_THRESHOLD_RST;
		gap_cfg      = pbd_pkg::MIN_INTERVAL_RST;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// opening sequence runs on the reset register values
		foreach (warmup_rows[r])
			push_sample(warmup_rows[r].sample, warmup_rows[r].stamp, warmup_rows[r].typed,
				warmup_rows[r].want);
		settle();
		clock_ms = 32'd1000;

		// lowest threshold, no debounce
		configure(4'd0, 16'd0);
		pulse_traffic(300);
		settle();
		// rise counter saturates at 15, never above a threshold of 15: never a beat
		configure(4'd15, 16'($urandom_range(0, 1000)));
		pulse_traffic(250);
		settle();
		// highest usable threshold with the longest debounce
		configure(4'd14, 16'hFFFF);
		pulse_traffic(300);
		settle();
		// stretch without any idling on either side
		steady = 1'b1;
		configure(4'd1, 16'd20);
		pulse_traffic(300);
		settle();
		steady = 1'b0;
		configure(4'($urandom_range(2, 13)), 16'($urandom_range(0, 65535)));
		pulse_traffic(350);
		settle();
		configure(4'd3, 16'($urandom_range(100, 400)));
		pulse_traffic(350);
		settle();

		$display("%0d samples sent, %0d reports checked, %0d beats counted by the detector",
			items_sent, reports_seen, beats_seen);
		$display("covered threshold 0 to 15, debounce 0 to 65535, clock wrap, %0d failures",
			fails);
		if (fails == 0)
			$display("PASS pulse_beat_detector");
		else
			$display("FAIL pulse_beat_detector");
		$finish;
	end

endmodule
